@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, ignored while reset is high
`define AM_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// implication into the next cycle, checked during reset too
`define AM_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication from reset");

`endif

@@ rtl/core/db4dwt_pkg.sv @@
// ----------------------------------------------------------------------------
// db4dwt_pkg
// Shared constants, types and the tap quantiser for the db4 analysis stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package db4dwt_pkg;

  // frame and window geometry
  localparam int LEN_W      = 16;
  localparam int POS_W      = 17;
  localparam int WIN_DEPTH  = 16;
  localparam int TAPS       = 8;
  localparam int TAP_BASE   = 6;
  localparam int MIRROR_POS = 8;
  localparam int MIN_LEN    = 8;
  localparam int NRES_MAX   = 7;
  localparam int Q_DEPTH    = 4;

  // filter taps scaled by 2^30
  localparam logic signed [31:0] TAP_LO_K [TAPS] = '{
    -32'sd11378874, 32'sd35307865, 32'sd33115682, -32'sd200827100,
    -32'sd30047344, 32'sd677403066, 32'sd767560661, 32'sd247366293
  };
  localparam logic signed [31:0] TAP_HI_K [TAPS] = '{
    -32'sd247366293, 32'sd767560661, -32'sd677403066, -32'sd30047344,
    32'sd200827100, 32'sd33115682, -32'sd35307865, -32'sd11378874
  };

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // round a tap magnitude half up to frac fraction bits, then restore the sign
  function automatic logic signed [31:0] quant_tap(input logic signed [31:0] k,
                                                   input int frac);
    logic [31:0] m;
    logic [31:0] r;
    m = k[31] ? $unsigned(-k) : $unsigned(k);
    if (frac >= 30) begin
      r = m;
    end else begin
      r = (m + (32'd1 << (29 - frac))) >> (30 - frac);
    end
    return k[31] ? -$signed(r) : $signed(r);
  endfunction

endpackage

@@ rtl/core/db4_dwt_analysis_stream.sv @@
// A pair is queued with the sample completing it, then passes product, sum and output registers.
// Throughput: one sample per cycle in a frame unless the queue is full, one pair per two samples.
// After the last sample of a frame the front runs the mirrored tail, up to 13 positions at
// one per cycle while the queue is not full, then closes the frame; no sample is taken before.
// Reset (synchronous, active high) empties the queue and pipeline and sets frame_length to 8.
// ----------------------------------------------------------------------------
// db4_dwt_analysis_stream
// One-level db4 wavelet analysis with symmetric extension, streaming top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module db4_dwt_analysis_stream #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 17,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [db4dwt_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH+1:0]  lo_coeff,
  output logic signed [SAMPLE_WIDTH+1:0]  hi_coeff,
  output logic                            last
);
  import db4dwt_pkg::*;

  localparam int Q_W = TAPS * SAMPLE_WIDTH + 1;

  logic           push;
  logic           pop;
  logic [Q_W-1:0] push_data;
  logic [Q_W-1:0] q_data;
  q_stat_t        q_stat;

  // front: window, frame tracking, tail mirroring
  db4dwt_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  // queue between front and filters
  db4dwt_queue #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_data),
    .pop    (pop),
    .rdata  (q_data),
    .q_stat (q_stat)
  );

  // back: filters and output register
  db4dwt_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lo_coeff  (lo_coeff),
    .hi_coeff  (hi_coeff),
    .last      (last)
  );

endmodule

@@ rtl/core/db4dwt_queue.sv @@
// ----------------------------------------------------------------------------
// db4dwt_queue
// Small register queue carrying filter windows from the front to the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module db4dwt_queue #(
  parameter int WIDTH = 129,
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output db4dwt_pkg::q_stat_t q_stat
);
  import db4dwt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  // status and head of queue
  assign rdata        = entries[rd_ptr];
  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == CNT_W'(DEPTH));

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/db4dwt_front.sv @@
// ----------------------------------------------------------------------------
// db4dwt_front
// Sample window, frame tracking, end mirroring and decimation; queues windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module db4dwt_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [db4dwt_pkg::LEN_W-1:0]             cfg_wr_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample,
  input  db4dwt_pkg::q_stat_t                      q_stat,
  output logic                                     push,
  output logic [db4dwt_pkg::TAPS*SAMPLE_WIDTH:0]   push_data
);
  import db4dwt_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH + 1 > POS_W) ? COUNT_WIDTH + 1 : POS_W;

  logic signed [SAMPLE_WIDTH-1:0] win    [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] w_sh   [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] w_new  [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] tail_mirror;
  logic [POS_W-1:0]       count;
  logic [POS_W-1:0]       cnt;
  logic [POS_W-1:0]       n_len;
  logic [POS_W-1:0]       tot;
  logic [POS_W-1:0]       tot_calc;
  logic [POS_W-1:0]       tot_sel;
  logic [COUNT_WIDTH-1:0] pairs;
  logic [LEN_W-1:0]       frame_length;
  logic [3:0]             k;
  logic [3:0]             k_next;
  logic [2:0]             nres;
  logic                   phase;
  logic                   tail;
  logic                   accept;
  logic                   tail_go;
  logic                   tail_done;
  logic                   more;
  logic                   is_final;
  logic                   emit;
  logic                   last_flag;

  // frame length and position bookkeeping
  always_comb begin
    cnt      = count + 1'b1;
    n_len    = (frame_length < LEN_W'(MIN_LEN)) ? POS_W'(MIN_LEN) : POS_W'(frame_length);
    is_final = (cnt >= n_len);
    tot_calc = is_final ? POS_W'(({1'b0, cnt} + (POS_W + 1)'(7)) >> 1)
                        : POS_W'(({1'b0, n_len} + (POS_W + 1)'(7)) >> 1);
    tot_sel  = tail ? tot : tot_calc;
    k_next   = k + 1'b1;
  end

  // handshake and step control
  always_comb begin
    more      = (CMP_W'(pairs) < CMP_W'(tot)) && (nres < 3'(NRES_MAX));
    in_ready  = !tail && !q_stat.full;
    accept    = in_valid && in_ready;
    tail_go   = tail && more && !q_stat.full;
    tail_done = tail && !more;
    emit      = phase && (tail || (cnt >= POS_W'(MIRROR_POS)));
    last_flag = ((CMP_W'(pairs) + CMP_W'(1)) == CMP_W'(tot_sel));
    push      = (accept || tail_go) && emit;
  end

  // next window: shift, start mirror at position eight, end mirror in the tail
  always_comb begin
    w_sh[0] = tail ? '0 : sample;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      w_sh[i] = win[i-1];
    end
    tail_mirror = '0;
    for (int j = 1; j <= MIRROR_POS; j++) begin
      if (k_next == 4'(j)) begin
        tail_mirror = w_sh[2*j-1];
      end
    end
    w_new = w_sh;
    if (!tail && (cnt == POS_W'(MIRROR_POS))) begin
      for (int i = 0; i < MIRROR_POS; i++) begin
        w_new[WIN_DEPTH-1-i] = w_sh[i];
      end
    end
    if (tail) begin
      w_new[0] = tail_mirror;
    end
  end

  // queue entry: filter window plus last flag
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      push_data[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = w_new[TAP_BASE+i];
    end
    push_data[TAPS*SAMPLE_WIDTH] = last_flag;
  end

  // window storage, every slot rewritten before it is read in a frame
  always_ff @(posedge clk) begin
    if (accept || tail_go) begin
      win <= w_new;
    end
  end

  // frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      phase        <= 1'b1;
      pairs        <= '0;
      tail         <= 1'b0;
      k            <= '0;
      nres         <= '0;
      tot          <= '0;
      frame_length <= LEN_W'(MIN_LEN);
    end else begin
      if (cfg_wr_en) begin
        frame_length <= cfg_wr_data;
      end
      if (accept) begin
        count <= cnt;
        pairs <= pairs + COUNT_WIDTH'(emit);
        nres  <= 3'(emit);
        k     <= '0;
        tot   <= tot_calc;
        tail  <= is_final;
        if (cnt >= POS_W'(MIRROR_POS)) begin
          phase <= !phase;
        end
      end else if (tail_go) begin
        k     <= k_next;
        pairs <= pairs + COUNT_WIDTH'(emit);
        nres  <= nres + 3'(emit);
        phase <= !phase;
      end else if (tail_done) begin
        count <= '0;
        phase <= 1'b1;
        pairs <= '0;
        tail  <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/db4dwt_back.sv @@
// ----------------------------------------------------------------------------
// db4dwt_back
// Eight-tap low-pass and high-pass filters, rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module db4dwt_back #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 17
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [db4dwt_pkg::TAPS*SAMPLE_WIDTH:0] q_data,
  input  db4dwt_pkg::q_stat_t                    q_stat,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH+1:0]         lo_coeff,
  output logic signed [SAMPLE_WIDTH+1:0]         hi_coeff,
  output logic                                   last
);
  import db4dwt_pkg::*;

  localparam int OUT_W  = SAMPLE_WIDTH + 2;
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W:0] HALF =
    {{(ACC_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [ACC_W:0] OMAX = {{(ACC_W + 2 - OUT_W){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0] OMIN = {{(ACC_W + 2 - OUT_W){1'b1}}, {(OUT_W - 1){1'b0}}};

  logic signed [COEF_W-1:0]       coef_lo [TAPS];
  logic signed [COEF_W-1:0]       coef_hi [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tap     [TAPS];
  logic signed [PROD_W-1:0]       prod_lo [TAPS];
  logic signed [PROD_W-1:0]       prod_hi [TAPS];
  logic signed [ACC_W-1:0]        sum4_lo [TAPS/2];
  logic signed [ACC_W-1:0]        sum4_hi [TAPS/2];
  logic signed [ACC_W-1:0]        sum2_lo [2];
  logic signed [ACC_W-1:0]        sum2_hi [2];
  logic signed [ACC_W:0]          rnd_lo;
  logic signed [ACC_W:0]          rnd_hi;
  logic signed [ACC_W:0]          sh_lo;
  logic signed [ACC_W:0]          sh_hi;
  logic signed [OUT_W-1:0]        sat_lo;
  logic signed [OUT_W-1:0]        sat_hi;
  logic                           en;
  logic                           v1;
  logic                           v2;
  logic                           v3;
  logic                           l1;
  logic                           l2;
  logic                           l3;

  // whole pipeline moves when the output register is free or being taken
  assign en  = !out_valid || out_ready;
  assign pop = en && !q_stat.empty;

  // quantised coefficients and window unpacking
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      coef_lo[i] = COEF_W'(quant_tap(TAP_LO_K[i], COEF_FRAC_BITS));
      coef_hi[i] = COEF_W'(quant_tap(TAP_HI_K[i], COEF_FRAC_BITS));
      tap[i]     = $signed(q_data[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
    end
  end

  // final add with rounding, floor shift and saturation
  always_comb begin
    rnd_lo = (ACC_W + 1)'(sum2_lo[0]) + (ACC_W + 1)'(sum2_lo[1]) + HALF;
    rnd_hi = (ACC_W + 1)'(sum2_hi[0]) + (ACC_W + 1)'(sum2_hi[1]) + HALF;
    sh_lo  = rnd_lo >>> COEF_FRAC_BITS;
    sh_hi  = rnd_hi >>> COEF_FRAC_BITS;
    priority if (sh_lo > OMAX) sat_lo = OMAX[OUT_W-1:0];
    else if (sh_lo < OMIN)     sat_lo = OMIN[OUT_W-1:0];
    else                       sat_lo = sh_lo[OUT_W-1:0];
    priority if (sh_hi > OMAX) sat_hi = OMAX[OUT_W-1:0];
    else if (sh_hi < OMIN)     sat_hi = OMIN[OUT_W-1:0];
    else                       sat_hi = sh_hi[OUT_W-1:0];
  end

  // datapath: products, pair sums, quad sums, output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_lo[i] <= tap[i] * coef_lo[i];
        prod_hi[i] <= tap[i] * coef_hi[i];
      end
      for (int j = 0; j < TAPS/2; j++) begin
        sum4_lo[j] <= ACC_W'(prod_lo[2*j]) + ACC_W'(prod_lo[2*j+1]);
        sum4_hi[j] <= ACC_W'(prod_hi[2*j]) + ACC_W'(prod_hi[2*j+1]);
      end
      for (int j = 0; j < 2; j++) begin
        sum2_lo[j] <= sum4_lo[2*j] + sum4_lo[2*j+1];
        sum2_hi[j] <= sum4_hi[2*j] + sum4_hi[2*j+1];
      end
      l1       <= q_data[TAPS*SAMPLE_WIDTH];
      l2       <= l1;
      l3       <= l2;
      last     <= l3;
      lo_coeff <= sat_lo;
      hi_coeff <= sat_hi;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= !q_stat.empty;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

@@ rtl/core/db4dwt_checker.sv @@
// ----------------------------------------------------------------------------
// db4dwt_checker
// Port-level checks on reset behaviour and output transfer holding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module db4dwt_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH+1:0] lo_coeff,
  input logic signed [SAMPLE_WIDTH+1:0] hi_coeff,
  input logic                           last
);

  // reset leaves no result pending and the input open
  `AM_NEXT_ALWAYS(a_rst_no_out, clk, rst, !out_valid)
  `AM_NEXT_ALWAYS(a_rst_ready, clk, rst, in_ready)

  // a stalled result stays offered and unchanged
  `AM_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `AM_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(lo_coeff) && $stable(hi_coeff) && $stable(last))

endmodule

bind db4_dwt_analysis_stream db4dwt_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .lo_coeff  (lo_coeff),
  .hi_coeff  (hi_coeff),
  .last      (last)
);
